// ===== design/ustd_pkg.sv =====
`timescale 1ns / 1ps
// ustd_pkg: types and constants shared by the utf-8 stream decoder modules
// no dependencies

package ustd_pkg;

  localparam int unsigned MAX_SEQ_BYTES = 6;
  localparam int unsigned QUEUE_DEPTH   = 2;

  localparam int unsigned CP_W   = 31;
  localparam int unsigned CNT_W  = 16;
  localparam int unsigned PEND_W = 3;
  localparam int unsigned PAY_W  = 7;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_buffer;
  } in_item_t;

  typedef struct packed {
    logic [CP_W-1:0]  code_point;
    logic             error;
    logic             last;
    logic [CNT_W-1:0] char_count;
  } out_item_t;

  typedef enum logic [1:0] {
    CLS_ASCII = 2'd0,
    CLS_CONT  = 2'd1,
    CLS_LEAD  = 2'd2,
    CLS_BAD   = 2'd3
  } byte_cls_t;

  // classified byte handed from the front end to the decode stage
  typedef struct packed {
    byte_cls_t         cls;
    logic [PEND_W-1:0] lead_pend;
    logic [PAY_W-1:0]  payload;
    logic              eob;
  } mid_item_t;

endpackage

// ===== design/ustd_fifo.sv =====
`timescale 1ns / 1ps
// ustd_fifo: small register-based queue with registered occupancy
// standalone, no package dependency

module ustd_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] item_in,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] item_out,
  output logic             empty
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign full     = (count_r == CW'(DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign item_out = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= item_in;
    end
  end

endmodule

// ===== design/ustd_front.sv =====
`timescale 1ns / 1ps
// ustd_front: input handshake and byte classification (ascii, continuation, lead, bad)
// depends on ustd_pkg

module ustd_front (
  input  logic                in_push,
  input  ustd_pkg::in_item_t  in_data,
  output logic                in_full,
  input  logic                mid_full,
  output logic                mid_push,
  output ustd_pkg::mid_item_t mid_item
);

  import ustd_pkg::*;

  logic [7:0]        b;
  logic [PEND_W-1:0] pend;
  logic [PAY_W-1:0]  lead_pay;
  logic              is_lead;

  assign b        = in_data.data_byte;
  assign in_full  = mid_full;
  assign mid_push = in_push;

  // lead byte length from the run of leading ones
  always_comb begin
    is_lead  = 1'b1;
    pend     = '0;
    lead_pay = '0;
    if (b[7:5] == 3'b110) begin
      pend     = PEND_W'(1);
      lead_pay = {2'b00, b[4:0]};
    end else if (b[7:4] == 4'b1110) begin
      pend     = PEND_W'(2);
      lead_pay = {3'b000, b[3:0]};
    end else if (b[7:3] == 5'b11110) begin
      pend     = PEND_W'(3);
      lead_pay = {4'b0000, b[2:0]};
    end else if (b[7:2] == 6'b111110) begin
      pend     = PEND_W'(4);
      lead_pay = {5'b00000, b[1:0]};
    end else if (b[7:1] == 7'b1111110) begin
      pend     = PEND_W'(5);
      lead_pay = {6'b000000, b[0]};
    end else begin
      is_lead  = 1'b0;
    end
  end

  always_comb begin
    mid_item.eob       = in_data.end_of_buffer;
    mid_item.lead_pend = '0;
    mid_item.payload   = '0;
    if (!b[7]) begin
      mid_item.cls     = CLS_ASCII;
      mid_item.payload = b[6:0];
    end else if (b[7:6] == 2'b10) begin
      mid_item.cls     = CLS_CONT;
      mid_item.payload = {1'b0, b[5:0]};
    end else if (is_lead && ({1'b0, pend} < 4'(MAX_SEQ_BYTES))) begin
      mid_item.cls       = CLS_LEAD;
      mid_item.lead_pend = pend;
      mid_item.payload   = lead_pay;
    end else begin
      mid_item.cls     = CLS_BAD;
    end
  end

endmodule

// ===== design/ustd_back.sv =====
`timescale 1ns / 1ps
// ustd_back: decode state (partial value, pending bytes, drop flag, count) and result build
// depends on ustd_pkg

module ustd_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [ustd_pkg::CNT_W-1:0] cfg_wdata,
  input  logic                  mid_empty,
  input  ustd_pkg::mid_item_t   mid_item,
  output logic                  mid_pop,
  input  logic                  res_full,
  output logic                  res_push,
  output ustd_pkg::out_item_t   res_item
);

  import ustd_pkg::*;

  logic [CNT_W-1:0]  limit_r;
  logic [CP_W-1:0]   pv_r, pv_nxt;
  logic [PEND_W-1:0] pend_r, pend_nxt;
  logic              drop_r, drop_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;

  logic              stopped, err, done, emit, go;
  logic [CP_W-1:0]   cp, shifted;

  assign go      = !mid_empty && !res_full;
  assign mid_pop = go;
  assign stopped = (limit_r != '0) && (cnt_r >= limit_r) && (pend_r == '0);
  assign shifted = {pv_r[CP_W-7:0], mid_item.payload[5:0]};

  always_comb begin
    pv_nxt   = pv_r;
    pend_nxt = pend_r;
    drop_nxt = drop_r;
    cnt_nxt  = cnt_r;
    err      = 1'b0;
    done     = 1'b0;
    emit     = 1'b0;
    cp       = '0;
    res_push = 1'b0;
    res_item = '{code_point: '0, error: 1'b0, last: 1'b0, char_count: '0};

    if (!drop_r && !stopped) begin
      if (pend_r == '0) begin
        case (mid_item.cls)
          CLS_ASCII: begin
            cp   = CP_W'(mid_item.payload);
            done = 1'b1;
          end
          CLS_LEAD: begin
            pv_nxt   = CP_W'(mid_item.payload);
            pend_nxt = mid_item.lead_pend;
          end
          default: err = 1'b1;
        endcase
      end else if (mid_item.cls == CLS_CONT) begin
        pv_nxt   = shifted;
        pend_nxt = pend_r - 1'b1;
        if (pend_r == PEND_W'(1)) begin
          cp     = shifted;
          pv_nxt = '0;
          done   = 1'b1;
        end
      end else begin
        err = 1'b1;
      end

      if (done) begin
        if (cnt_r != CNT_MAX) begin
          cnt_nxt = cnt_r + 1'b1;
        end
        emit = (limit_r != '0);
      end
      // buffer ends in the middle of a sequence
      if (mid_item.eob && (pend_nxt != '0)) begin
        err = 1'b1;
      end
      if (err) begin
        drop_nxt = 1'b1;
        pend_nxt = '0;
        pv_nxt   = '0;
      end
    end

    res_item.char_count = cnt_nxt;
    if (mid_item.eob) begin
      res_push            = go;
      res_item.code_point = (emit && !drop_nxt) ? cp : '0;
      res_item.error      = drop_nxt;
      res_item.last       = 1'b1;
      pv_nxt   = '0;
      pend_nxt = '0;
      drop_nxt = 1'b0;
      cnt_nxt  = '0;
    end else if (err) begin
      res_push       = go;
      res_item.error = 1'b1;
    end else if (emit) begin
      res_push            = go;
      res_item.code_point = cp;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= '0;
      pv_r    <= '0;
      pend_r  <= '0;
      drop_r  <= 1'b0;
      cnt_r   <= '0;
    end else begin
      if (cfg_we) begin
        limit_r <= cfg_wdata;
      end
      if (go) begin
        pv_r   <= pv_nxt;
        pend_r <= pend_nxt;
        drop_r <= drop_nxt;
        cnt_r  <= cnt_nxt;
      end
    end
  end

endmodule

// ===== design/utf8_stream_decoder_core.sv =====
`timescale 1ns / 1ps
// utf8_stream_decoder_core: legacy utf-8 (one to six byte) stream decoder, top level
// depends on ustd_pkg, ustd_front, ustd_fifo, ustd_back
//
// usage:
//   input side is a queue: drive in_data and raise in_push; the byte is taken
//   at an edge where in_full is low. end_of_buffer marks the final byte.
//   result side is a queue: while out_empty is low the oldest result is on
//   out_data; raise out_pop to take it.
//   cfg_we/cfg_wdata write char_limit (0 = count only); write only when idle.
// timing:
//   one byte per cycle sustained while the result queue is not full; a byte taken
//   is registered in the byte queue, the decode stage reads it from there and
//   registers any result in the result queue, whose head shows on out_data.
//   the decode stage updates its state once per byte, which sets the rate.
// stalls and reset:
//   when out_pop stays low the result queue fills, the decode stage holds,
//   and then the byte queue fills and raises in_full. no byte is lost.
//   rst_n (synchronous, active low) empties both queues, clears the decode
//   state and sets char_limit to 0.

module utf8_stream_decoder_core #(
  parameter int unsigned QUEUE_DEPTH = ustd_pkg::QUEUE_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_push,
  input  ustd_pkg::in_item_t         in_data,
  output logic                       in_full,
  output logic                       out_empty,
  input  logic                       out_pop,
  output ustd_pkg::out_item_t        out_data,
  input  logic                       cfg_we,
  input  logic [ustd_pkg::CNT_W-1:0] cfg_wdata
);

  import ustd_pkg::*;

  mid_item_t mid_in, mid_out;
  out_item_t res_item;
  logic      mid_push, mid_full, mid_empty, mid_pop;
  logic      res_push, res_full;

  ustd_front u_front (
    .in_push  (in_push),
    .in_data  (in_data),
    .in_full  (in_full),
    .mid_full (mid_full),
    .mid_push (mid_push),
    .mid_item (mid_in)
  );

  ustd_fifo #(
    .WIDTH ($bits(mid_item_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_mid_q (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (mid_push),
    .item_in  (mid_in),
    .full     (mid_full),
    .pop      (mid_pop),
    .item_out (mid_out),
    .empty    (mid_empty)
  );

  ustd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .mid_empty (mid_empty),
    .mid_item  (mid_out),
    .mid_pop   (mid_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res_item  (res_item)
  );

  ustd_fifo #(
    .WIDTH ($bits(out_item_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_res_q (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (res_push),
    .item_in  (res_item),
    .full     (res_full),
    .pop      (out_pop),
    .item_out (out_data),
    .empty    (out_empty)
  );

endmodule
